// ===== rtl/bspl_pkg.sv =====
// Shared types and constants for the bounded sorted pair list.
`default_nettype none
package bspl_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int TILE_BITS   = 10;
    localparam int TILE_W      = 10;
    localparam int COST_W      = 32;
    localparam int CFG_W       = 7;
    localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_POP    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ADD_INSERTED = 2'd0,
        ADD_EVICTED  = 2'd1,
        ADD_REJECTED = 2'd2
    } t_add_outcome;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [TILE_BITS-1:0] tile_a;
        logic [TILE_BITS-1:0] tile_b;
        logic [COST_W-1:0]    cost;
    } t_entry;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic step_done;
    } t_dp_status;

endpackage
`default_nettype wire

// ===== rtl/bspl_ctrl.sv =====
// Controller state machine for the bounded sorted pair list.
`default_nettype none
module bspl_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire bspl_pkg::t_dp_status i_status,
    output bspl_pkg::t_dp_cmd         o_cmd
);

    bspl_pkg::t_state r_state;
    bspl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bspl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bspl_pkg::S_IDLE: begin
                if (start) n_state = bspl_pkg::S_EXEC;
            end
            bspl_pkg::S_EXEC: begin
                if (i_status.step_done) n_state = bspl_pkg::S_IDLE;
            end
            default: n_state = bspl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b0;
        unique case (r_state)
            bspl_pkg::S_IDLE: begin
                o_cmd.load = start;
            end
            bspl_pkg::S_EXEC: begin
                busy         = 1'b1;
                o_cmd.step   = 1'b1;
                o_cmd.finish = i_status.step_done;
            end
            default: busy = 1'b0;
        endcase
    end

    // At most one of the load and step commands can be active at a time.
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load && o_cmd.step))
        else $error("load and step asserted together");
    // A finished operation always returns the controller to idle.
    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_state == bspl_pkg::S_IDLE)
        else $error("controller did not return to idle after finish");
    // A load is always followed by execution.
    a_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.step)
        else $error("load not followed by step");

endmodule
`default_nettype wire

// ===== rtl/bspl_dp.sv =====
// Datapath of the bounded sorted pair list: entry cells, count and result registers.
`default_nettype none
module bspl_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire bspl_pkg::t_dp_cmd                   i_cmd,
    output bspl_pkg::t_dp_status                     o_status,
    input  wire logic [1:0]                          i_mode,
    input  wire logic [bspl_pkg::TILE_W-1:0]         i_first_tile,
    input  wire logic [bspl_pkg::TILE_W-1:0]         i_second_tile,
    input  wire logic [bspl_pkg::COST_W-1:0]         i_cost,
    input  wire logic                                i_cfg_write,
    input  wire logic [bspl_pkg::CFG_W-1:0]          i_cfg_data,
    output logic                                     o_done,
    output logic                                     o_pop_valid,
    output logic [bspl_pkg::TILE_W-1:0]              o_out_first_tile,
    output logic [bspl_pkg::TILE_W-1:0]              o_out_second_tile,
    output logic [bspl_pkg::COST_W-1:0]              o_out_cost,
    output logic [1:0]                               o_add_outcome,
    output logic [bspl_pkg::CFG_W-1:0]               o_entry_count
);

    localparam int N  = bspl_pkg::MAX_ENTRIES;
    localparam int CW = bspl_pkg::COUNT_W;

    bspl_pkg::t_entry                  r_cell [N];
    bspl_pkg::t_entry                  n_cell [N];
    logic [CW-1:0]                     r_total;
    logic [CW-1:0]                     n_total;
    logic [bspl_pkg::CFG_W-1:0]        r_cap_cfg;
    bspl_pkg::t_mode                   r_mode;
    logic [bspl_pkg::TILE_BITS-1:0]    r_ta;
    logic [bspl_pkg::TILE_BITS-1:0]    r_tb;
    logic [bspl_pkg::COST_W-1:0]       r_key;

    logic                              r_done;
    logic                              r_pop_valid;
    bspl_pkg::t_entry                  r_pop_entry;
    bspl_pkg::t_add_outcome            r_outcome;
    logic [CW-1:0]                     r_count_out;

    logic [N-1:0]                      valid;
    logic [N-1:0]                      lt;
    logic [N-1:0]                      sel;
    logic [N-1:0]                      sel_prev;
    logic [N-1:0]                      hit;
    logic [N-1:0]                      after_hit;
    logic [CW-1:0]                     cap;
    logic                              full;
    logic                              reject;
    logic                              any_hit;
    logic                              n_pop_valid;
    bspl_pkg::t_entry                  n_pop_entry;
    bspl_pkg::t_add_outcome            n_outcome;
    bspl_pkg::t_entry                  new_entry;

    // Effective capacity: zero acts as one, large values clamp to the cell count.
    always_comb begin
        if (r_cap_cfg == '0) begin
            cap = CW'(1);
        end else if (32'(r_cap_cfg) > N) begin
            cap = CW'(N);
        end else begin
            cap = CW'(r_cap_cfg);
        end
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            valid[i] = CW'(i) < r_total;
            lt[i]    = valid[i] && (r_key < r_cell[i].cost);
            sel[i]   = !valid[i] || (r_key < r_cell[i].cost);
            hit[i]   = valid[i] && ((r_cell[i].tile_a == r_ta) || (r_cell[i].tile_b == r_ta) ||
                                    (r_cell[i].tile_a == r_tb) || (r_cell[i].tile_b == r_tb));
        end
        sel_prev  = {sel[N-2:0], 1'b0};
        // Every cell at or above the first hit takes its upper neighbor.
        after_hit = hit | (~hit + N'(1));
        any_hit   = |hit;
        full      = r_total >= cap;
        reject    = full && !(|lt);
    end

    assign new_entry.tile_a = r_ta;
    assign new_entry.tile_b = r_tb;
    assign new_entry.cost   = r_key;

    always_comb begin
        n_cell      = r_cell;
        n_total     = r_total;
        n_pop_valid = 1'b0;
        n_pop_entry = '0;
        n_outcome   = bspl_pkg::ADD_INSERTED;
        unique case (r_mode)
            bspl_pkg::MODE_ADD: begin
                if (reject) begin
                    n_outcome = bspl_pkg::ADD_REJECTED;
                end else begin
                    for (int i = 0; i < N; i++) begin
                        if (sel_prev[i]) begin
                            n_cell[i] = (i == 0) ? new_entry : r_cell[(i == 0) ? 0 : i - 1];
                        end else if (sel[i]) begin
                            n_cell[i] = new_entry;
                        end
                    end
                    if (full) begin
                        n_outcome = bspl_pkg::ADD_EVICTED;
                    end else begin
                        n_total = r_total + CW'(1);
                    end
                end
            end
            bspl_pkg::MODE_POP: begin
                if (r_total != '0) begin
                    n_pop_valid = 1'b1;
                    n_pop_entry = r_cell[0];
                    for (int i = 0; i < N - 1; i++) begin
                        n_cell[i] = r_cell[i+1];
                    end
                    n_total = r_total - CW'(1);
                end
            end
            bspl_pkg::MODE_REMOVE: begin
                if (any_hit) begin
                    for (int i = 0; i < N - 1; i++) begin
                        if (after_hit[i]) n_cell[i] = r_cell[i+1];
                    end
                    n_total = r_total - CW'(1);
                end
            end
            bspl_pkg::MODE_CLEAR: begin
                n_total = '0;
            end
            default: n_total = r_total;
        endcase
    end

    assign o_status.step_done = (r_mode != bspl_pkg::MODE_REMOVE) || !any_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_cap_cfg <= bspl_pkg::CFG_W'(bspl_pkg::MAX_ENTRIES);
            r_done    <= 1'b0;
        end else begin
            if (i_cfg_write) r_cap_cfg <= i_cfg_data;
            if (i_cmd.step) r_total <= n_total;
            r_done <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= bspl_pkg::t_mode'(i_mode);
            r_ta   <= i_first_tile[bspl_pkg::TILE_BITS-1:0];
            r_tb   <= i_second_tile[bspl_pkg::TILE_BITS-1:0];
            r_key  <= i_cost;
        end
        if (i_cmd.step) r_cell <= n_cell;
        if (i_cmd.finish) begin
            r_pop_valid <= n_pop_valid;
            r_pop_entry <= n_pop_entry;
            r_outcome   <= n_outcome;
            r_count_out <= n_total;
        end
    end

    assign o_done            = r_done;
    assign o_pop_valid       = r_pop_valid;
    assign o_out_first_tile  = bspl_pkg::TILE_W'(r_pop_entry.tile_a);
    assign o_out_second_tile = bspl_pkg::TILE_W'(r_pop_entry.tile_b);
    assign o_out_cost        = r_pop_entry.cost;
    assign o_add_outcome     = r_outcome;
    assign o_entry_count     = bspl_pkg::CFG_W'(r_count_out);

    // The entry count never exceeds the number of cells.
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_total) <= N)
        else $error("entry count exceeds cell count");
    // A successful pop leaves the add outcome at its default, inserted.
    a_pop_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_pop_valid) |-> r_outcome == bspl_pkg::ADD_INSERTED)
        else $error("pop result carries an add outcome");
    // Result strobes never come back to back.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe lasted more than one cycle");
    // An evicting or rejected add leaves the count unchanged.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_mode == bspl_pkg::MODE_ADD && full) |=> $stable(r_total))
        else $error("full add changed the entry count");

endmodule
`default_nettype wire

// ===== rtl/bounded_sorted_pair_list_top.sv =====
// Top level of the bounded sorted pair list.
`default_nettype none
// The block keeps up to 64 entries (two tile numbers and a 32-bit cost) in ascending
// cost order, equal costs in arrival order. An operation is transferred when start is
// high and busy is low. Add, pop and clear capture the operation on transfer and then
// execute once, with every cell comparing and shifting in parallel. Remove keeps
// executing while any entry matches either tile, because the cell array deletes
// the first matching entry in each cycle until none is left.
// The result appears for exactly one cycle with o_done high; the receiver cannot stall
// it and must take it in that cycle. The capacity register is transferred on the
// configuration channel, which is ready whenever the block is idle; write it only
// between operations. Entries held above a newly lowered capacity are kept.
module bounded_sorted_pair_list_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  i_mode,
    input  wire logic [bspl_pkg::TILE_W-1:0] i_first_tile,
    input  wire logic [bspl_pkg::TILE_W-1:0] i_second_tile,
    input  wire logic [bspl_pkg::COST_W-1:0] i_cost,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [bspl_pkg::CFG_W-1:0]  i_cfg_data,
    output logic                             o_done,
    output logic                             o_pop_valid,
    output logic [bspl_pkg::TILE_W-1:0]      o_out_first_tile,
    output logic [bspl_pkg::TILE_W-1:0]      o_out_second_tile,
    output logic [bspl_pkg::COST_W-1:0]      o_out_cost,
    output logic [1:0]                       o_add_outcome,
    output logic [bspl_pkg::CFG_W-1:0]       o_entry_count
);

    bspl_pkg::t_dp_cmd    cmd;
    bspl_pkg::t_dp_status status;

    // The configuration channel is open whenever no operation is in flight.
    assign o_cfg_ready = !busy;

    bspl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    bspl_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_mode            (i_mode),
        .i_first_tile      (i_first_tile),
        .i_second_tile     (i_second_tile),
        .i_cost            (i_cost),
        .i_cfg_write       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_done            (o_done),
        .o_pop_valid       (o_pop_valid),
        .o_out_first_tile  (o_out_first_tile),
        .o_out_second_tile (o_out_second_tile),
        .o_out_cost        (o_out_cost),
        .o_add_outcome     (o_add_outcome),
        .o_entry_count     (o_entry_count)
    );

endmodule
`default_nettype wire
